/* sv/neighbor_table_next_hop_select_top_assert.svh */
`ifndef NEIGHBOR_TABLE_NEXT_HOP_SELECT_TOP_ASSERT_SVH
`define NEIGHBOR_TABLE_NEXT_HOP_SELECT_TOP_ASSERT_SVH

// concurrent checks, removed for synthesis
`ifndef SYNTHESIS
`define NTS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("nts check failed");
`define NTS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("nts check failed");
`else
`define NTS_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define NTS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif

`endif

/* sv/nts_pkg.sv */
package nts_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [1:0] CMD_BEACON = 2'd0;
  localparam logic [1:0] CMD_EXPIRE = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;

  localparam logic [1:0] MODE_GREEDY = 2'd0;
  localparam logic [1:0] MODE_LET    = 2'd1;
  localparam logic [1:0] MODE_STABLE = 2'd2;

  localparam logic [2:0] STAT_UPDATED = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_EXPIRED = 3'd2;
  localparam logic [2:0] STAT_ARRIVED = 3'd3;
  localparam logic [2:0] STAT_FORWARD = 3'd4;
  localparam logic [2:0] STAT_NO_HOP  = 3'd5;

  localparam logic [2:0] CFG_RANGE   = 3'd0;
  localparam logic [2:0] CFG_SPEED   = 3'd1;
  localparam logic [2:0] CFG_ARRIVAL = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT = 3'd3;
  localparam logic [2:0] CFG_OWN_ID  = 3'd4;

  localparam logic [13:0] LET_MAX     = 14'd15984;
  localparam logic [33:0] SLOW_SPEED2 = 34'd655;
  localparam logic [5:0]  REMOVED_MAX = 6'd63;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [31:0]        seen_ms;
    logic [13:0]        link_time;
    logic               stable;
  } nts_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] radicand;
  } nts_sqrt_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [33:0] divisor;
  } nts_div_req_t;

endpackage

/* sv/neighbor_table_next_hop_select_top.sv */
// beacon: up to three root and three 64-step divide operations, through one shared
//   root unit and one shared divider, then a read-and-check walk over every entry
// expire: read, check each entry; select: read, load, square, compare; one read port
// one command at a time; the result strobe lasts one cycle and cannot be held off
// synchronous reset: control and config registers to defaults, all entries invalid
module neighbor_table_next_hop_select_top #(
  parameter int TABLE_ENTRIES = nts_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_now_ms,
  input  logic [15:0]        in_node_id,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [23:0] in_own_x,
  input  logic signed [23:0] in_own_y,
  input  logic signed [15:0] in_own_vx,
  input  logic signed [15:0] in_own_vy,
  input  logic [1:0]         in_route_mode,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [15:0]        out_hop_id,
  output logic               out_link_stable,
  output logic [13:0]        out_link_time,
  output logic [5:0]         out_removed_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import nts_pkg::*;

`include "neighbor_table_next_hop_select_top_assert.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_MUL    = 5'd2;
  localparam logic [4:0] B_SUM    = 5'd3;
  localparam logic [4:0] B_SQD_GO = 5'd4;
  localparam logic [4:0] B_SQD_W  = 5'd5;
  localparam logic [4:0] B_SQV_GO = 5'd6;
  localparam logic [4:0] B_SQV_W  = 5'd7;
  localparam logic [4:0] B_SEP_GO = 5'd8;
  localparam logic [4:0] B_SEP_W  = 5'd9;
  localparam logic [4:0] B_CD_GO  = 5'd10;
  localparam logic [4:0] B_CD_W   = 5'd11;
  localparam logic [4:0] B_RSQ    = 5'd12;
  localparam logic [4:0] B_SQR_GO = 5'd13;
  localparam logic [4:0] B_SQR_W  = 5'd14;
  localparam logic [4:0] B_TR_GO  = 5'd15;
  localparam logic [4:0] B_TR_W   = 5'd16;
  localparam logic [4:0] B_TC_GO  = 5'd17;
  localparam logic [4:0] B_TC_W   = 5'd18;
  localparam logic [4:0] B_RD     = 5'd19;
  localparam logic [4:0] B_CHK    = 5'd20;
  localparam logic [4:0] B_WR     = 5'd21;
  localparam logic [4:0] X_RD     = 5'd22;
  localparam logic [4:0] X_CHK    = 5'd23;
  localparam logic [4:0] S_ARR    = 5'd24;
  localparam logic [4:0] S_RD     = 5'd25;
  localparam logic [4:0] S_DAT    = 5'd26;
  localparam logic [4:0] S_SQE    = 5'd27;
  localparam logic [4:0] S_CMP    = 5'd28;
  localparam logic [4:0] S_FIN    = 5'd29;

  logic [4:0] state_r;

  logic [22:0] cfg_range_r;
  logic [14:0] cfg_speed_r;
  logic [22:0] cfg_arrival_r;
  logic [31:0] cfg_timeout_r;
  logic [15:0] cfg_own_id_r;

  logic [1:0]         lat_cmd_r;
  logic [31:0]        lat_now_r;
  logic [15:0]        lat_id_r;
  logic signed [23:0] lat_pos_x_r;
  logic signed [23:0] lat_pos_y_r;
  logic signed [15:0] lat_vel_x_r;
  logic signed [15:0] lat_vel_y_r;
  logic signed [23:0] lat_own_x_r;
  logic signed [23:0] lat_own_y_r;
  logic signed [15:0] lat_own_vx_r;
  logic signed [15:0] lat_own_vy_r;
  logic [1:0]         lat_mode_r;

  logic signed [24:0] px_r;
  logic signed [24:0] py_r;
  logic signed [16:0] vx_r;
  logic signed [16:0] vy_r;
  logic signed [49:0] mpx_r;
  logic signed [49:0] mpy_r;
  logic signed [33:0] mvx_r;
  logic signed [33:0] mvy_r;
  logic signed [41:0] mdx_r;
  logic signed [41:0] mdy_r;
  logic signed [41:0] mcx_r;
  logic signed [41:0] mcy_r;
  logic [29:0]        lim2_r;
  logic [45:0]        ar2_r;

  logic [49:0] p2_r;
  logic [33:0] v2_r;
  logic        dneg_r;
  logic [41:0] dabs_r;
  logic [41:0] acr_r;
  logic        stable_r;
  logic [31:0] distf_r;
  logic [23:0] speedf_r;
  logic [29:0] cdf_r;
  logic [59:0] rf2_r;
  logic [59:0] cd2_r;
  logic [30:0] s_r;
  logic [15:0] tr_r;
  logic [13:0] lt_r;

  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [IDX_W-1:0]         cnt_r;
  logic                     slot_found_r;
  logic [IDX_W-1:0]         slot_r;
  logic                     free_found_r;
  logic [IDX_W-1:0]         free_r;
  logic [5:0]               removed_r;

  logic [49:0]        own2_r;
  logic signed [24:0] ex_r;
  logic signed [24:0] ey_r;
  logic signed [49:0] mex_r;
  logic signed [49:0] mey_r;
  logic [15:0]        eid_r;
  logic [13:0]        elt_r;
  logic               est_r;
  logic               evld_r;
  logic               g_found_r;
  logic [49:0]        g_d_r;
  logic [15:0]        g_id_r;
  logic               st_found_r;
  logic [49:0]        st_d_r;
  logic [15:0]        st_id_r;
  logic               l_found_r;
  logic [13:0]        l_lt_r;
  logic [15:0]        l_id_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_hop_id_r;
  logic        out_link_stable_r;
  logic [13:0] out_link_time_r;
  logic [5:0]  out_removed_r;

  logic [29:0]        rf;
  logic               accept;
  logic signed [42:0] dsum;
  logic signed [42:0] csum;
  logic [49:0]        own2;
  logic [49:0]        nd;
  logic [31:0]        age;
  logic [16:0]        let_sum;
  logic               g_better;
  logic               st_better;
  logic               l_better;
  logic               near;

  nts_sqrt_req_t sq_req;
  logic          sq_done;
  logic [31:0]   sq_root;
  nts_div_req_t  dv_req;
  logic          dv_done;
  logic [63:0]   dv_q;

  logic       mem_rd_en;
  logic       mem_wr_en;
  nts_entry_t mem_wr_data;
  nts_entry_t mem_rd_data;

  function automatic logic [15:0] sat16(input logic [63:0] v);
    return (|v[63:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [13:0] sat_let(input logic [63:0] v);
    return (v > 64'(LET_MAX)) ? LET_MAX : v[13:0];
  endfunction

  assign rf     = {cfg_range_r, 7'd0};
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign dsum    = 43'(mdx_r) + 43'(mdy_r);
  assign csum    = 43'(mcx_r) - 43'(mcy_r);
  assign own2    = $unsigned(mpx_r) + $unsigned(mpy_r);
  assign nd      = $unsigned(mex_r) + $unsigned(mey_r);
  assign age     = lat_now_r - mem_rd_data.seen_ms;
  assign let_sum = 17'(tr_r) + 17'(sat16(dv_q));
  assign near    = evld_r && (nd < own2_r);

  assign g_better  = near && (!g_found_r || nd < g_d_r || (nd == g_d_r && eid_r < g_id_r));
  assign st_better = near && est_r &&
                     (!st_found_r || nd < st_d_r || (nd == st_d_r && eid_r < st_id_r));
  assign l_better  = near && (l_found_r ? (elt_r > l_lt_r || (elt_r == l_lt_r && eid_r < l_id_r))
                                        : (elt_r != 14'd0));

  always_comb begin
    sq_req.start    = 1'b0;
    sq_req.radicand = {p2_r, 14'd0};
    case (state_r)
      B_SQD_GO: sq_req.start = 1'b1;
      B_SQV_GO: begin
        sq_req.start    = 1'b1;
        sq_req.radicand = {16'd0, v2_r, 14'd0};
      end
      B_SQR_GO: begin
        sq_req.start    = 1'b1;
        sq_req.radicand = {4'd0, 60'(rf2_r - cd2_r)};
      end
      default: ;
    endcase
  end

  always_comb begin
    dv_req.start    = 1'b0;
    dv_req.dividend = {25'd0, 30'(rf - distf_r[29:0]), 9'd0};
    dv_req.divisor  = {10'd0, speedf_r};
    case (state_r)
      B_SEP_GO: dv_req.start = 1'b1;
      B_CD_GO: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = {8'd0, acr_r, 14'd0};
      end
      B_TR_GO: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = {23'd0, s_r, 10'd0};
      end
      B_TC_GO: begin
        dv_req.start    = 1'b1;
        dv_req.dividend = {13'd0, dabs_r, 9'd0};
        dv_req.divisor  = v2_r;
      end
      default: ;
    endcase
  end

  assign mem_rd_en = (state_r == B_RD) || (state_r == X_RD) || (state_r == S_RD);
  assign mem_wr_en = (state_r == B_WR) && (slot_found_r || free_found_r);

  always_comb begin
    mem_wr_data.id        = lat_id_r;
    mem_wr_data.pos_x     = lat_pos_x_r;
    mem_wr_data.pos_y     = lat_pos_y_r;
    mem_wr_data.vel_x     = lat_vel_x_r;
    mem_wr_data.vel_y     = lat_vel_y_r;
    mem_wr_data.seen_ms   = lat_now_r;
    mem_wr_data.link_time = lt_r;
    mem_wr_data.stable    = stable_r;
  end

  nts_mem #(
    .ENTRIES (TABLE_ENTRIES),
    .ADDR_W  (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (slot_found_r ? slot_r : free_r),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (cnt_r),
    .rd_data (mem_rd_data)
  );

  nts_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .done  (sq_done),
    .root  (sq_root)
  );

  nts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dv_req),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_range_r   <= 23'd2400;
      cfg_speed_r   <= 15'd3584;
      cfg_arrival_r <= 23'd400;
      cfg_timeout_r <= 32'd5000;
      cfg_own_id_r  <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE:   cfg_range_r   <= cfg_data[22:0];
        CFG_SPEED:   cfg_speed_r   <= cfg_data[14:0];
        CFG_ARRIVAL: cfg_arrival_r <= cfg_data[22:0];
        CFG_TIMEOUT: cfg_timeout_r <= cfg_data;
        CFG_OWN_ID:  cfg_own_id_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_cmd_r    <= in_command;
      lat_now_r    <= in_now_ms;
      lat_id_r     <= in_node_id;
      lat_pos_x_r  <= in_pos_x;
      lat_pos_y_r  <= in_pos_y;
      lat_vel_x_r  <= in_vel_x;
      lat_vel_y_r  <= in_vel_y;
      lat_own_x_r  <= in_own_x;
      lat_own_y_r  <= in_own_y;
      lat_own_vx_r <= in_own_vx;
      lat_own_vy_r <= in_own_vy;
      lat_mode_r   <= in_route_mode;
    end
    case (state_r)
      S_DISP: begin
        px_r <= 25'(lat_pos_x_r) - 25'(lat_own_x_r);
        py_r <= 25'(lat_pos_y_r) - 25'(lat_own_y_r);
        vx_r <= 17'(lat_vel_x_r) - 17'(lat_own_vx_r);
        vy_r <= 17'(lat_vel_y_r) - 17'(lat_own_vy_r);
      end
      S_MUL: begin
        mpx_r  <= px_r * px_r;
        mpy_r  <= py_r * py_r;
        mvx_r  <= vx_r * vx_r;
        mvy_r  <= vy_r * vy_r;
        mdx_r  <= px_r * vx_r;
        mdy_r  <= py_r * vy_r;
        mcx_r  <= px_r * vy_r;
        mcy_r  <= py_r * vx_r;
        lim2_r <= 30'(cfg_speed_r) * 30'(cfg_speed_r);
        ar2_r  <= 46'(cfg_arrival_r) * 46'(cfg_arrival_r);
      end
      B_SUM: begin
        p2_r     <= own2;
        v2_r     <= $unsigned(mvx_r) + $unsigned(mvy_r);
        dneg_r   <= dsum[42];
        dabs_r   <= dsum[42] ? 42'(-dsum) : 42'(dsum);
        acr_r    <= csum[42] ? 42'(-csum) : 42'(csum);
        stable_r <= (34'($unsigned(mvx_r)) + 34'($unsigned(mvy_r))) <= 34'(lim2_r);
        lt_r     <= LET_MAX;
      end
      B_SQD_W: if (sq_done) distf_r <= sq_root;
      B_SQV_W: begin
        if (sq_done) begin
          speedf_r <= sq_root[23:0];
          if (!dneg_r && {2'd0, rf} <= distf_r) begin
            lt_r <= '0;
          end
        end
      end
      B_SEP_W: if (dv_done) lt_r <= sat_let(dv_q);
      B_CD_W: begin
        if (dv_done) begin
          cdf_r <= dv_q[29:0];
          if (dv_q > 64'(rf)) begin
            lt_r <= '0;
          end
        end
      end
      B_RSQ: begin
        rf2_r <= 60'(rf) * 60'(rf);
        cd2_r <= 60'(cdf_r) * 60'(cdf_r);
      end
      B_SQR_W: if (sq_done) s_r <= sq_root[30:0];
      B_TR_W:  if (dv_done) tr_r <= sat16(dv_q);
      B_TC_W:  if (dv_done) lt_r <= sat_let(64'(let_sum));
      S_ARR:   own2_r <= own2;
      S_DAT: begin
        ex_r   <= 25'($signed(mem_rd_data.pos_x)) - 25'(lat_pos_x_r);
        ey_r   <= 25'($signed(mem_rd_data.pos_y)) - 25'(lat_pos_y_r);
        eid_r  <= mem_rd_data.id;
        elt_r  <= mem_rd_data.link_time;
        est_r  <= mem_rd_data.stable;
        evld_r <= vld_r[cnt_r];
      end
      S_SQE: begin
        mex_r <= ex_r * ex_r;
        mey_r <= ey_r * ey_r;
      end
      S_CMP: begin
        if (g_better) begin
          g_d_r  <= nd;
          g_id_r <= eid_r;
        end
        if (st_better) begin
          st_d_r  <= nd;
          st_id_r <= eid_r;
        end
        if (l_better) begin
          l_lt_r <= elt_r;
          l_id_r <= eid_r;
        end
      end
      B_CHK: begin
        if (vld_r[cnt_r] && mem_rd_data.id == lat_id_r && !slot_found_r) begin
          slot_r <= cnt_r;
        end
        if (!vld_r[cnt_r] && !free_found_r) begin
          free_r <= cnt_r;
        end
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      cnt_r        <= '0;
      slot_found_r <= 1'b0;
      free_found_r <= 1'b0;
      removed_r    <= '0;
      g_found_r    <= 1'b0;
      st_found_r   <= 1'b0;
      l_found_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r        <= '0;
          slot_found_r <= 1'b0;
          free_found_r <= 1'b0;
          removed_r    <= '0;
          g_found_r    <= 1'b0;
          st_found_r   <= 1'b0;
          l_found_r    <= 1'b0;
          if (accept) begin
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          case (lat_cmd_r)
            CMD_BEACON: state_r <= S_MUL;
            CMD_EXPIRE: state_r <= X_RD;
            CMD_SELECT: state_r <= S_MUL;
            default:    state_r <= S_IDLE;
          endcase
        end
        S_MUL: state_r <= (lat_cmd_r == CMD_SELECT) ? S_ARR : B_SUM;
        B_SUM: begin
          if ($unsigned(mvx_r) + $unsigned(mvy_r) <= SLOW_SPEED2) begin
            state_r <= B_RD;
          end else begin
            state_r <= B_SQD_GO;
          end
        end
        B_SQD_GO: state_r <= B_SQD_W;
        B_SQD_W:  if (sq_done) state_r <= B_SQV_GO;
        B_SQV_GO: state_r <= B_SQV_W;
        B_SQV_W: begin
          if (sq_done) begin
            if (dneg_r) begin
              state_r <= B_CD_GO;
            end else if ({2'd0, rf} <= distf_r) begin
              state_r <= B_RD;
            end else begin
              state_r <= B_SEP_GO;
            end
          end
        end
        B_SEP_GO: state_r <= B_SEP_W;
        B_SEP_W:  if (dv_done) state_r <= B_RD;
        B_CD_GO:  state_r <= B_CD_W;
        B_CD_W: begin
          if (dv_done) begin
            state_r <= (dv_q > 64'(rf)) ? B_RD : B_RSQ;
          end
        end
        B_RSQ:    state_r <= B_SQR_GO;
        B_SQR_GO: state_r <= B_SQR_W;
        B_SQR_W:  if (sq_done) state_r <= B_TR_GO;
        B_TR_GO:  state_r <= B_TR_W;
        B_TR_W:   if (dv_done) state_r <= B_TC_GO;
        B_TC_GO:  state_r <= B_TC_W;
        B_TC_W:   if (dv_done) state_r <= B_RD;
        B_RD:     state_r <= B_CHK;
        B_CHK: begin
          if (vld_r[cnt_r] && mem_rd_data.id == lat_id_r) begin
            slot_found_r <= 1'b1;
          end
          if (!vld_r[cnt_r]) begin
            free_found_r <= 1'b1;
          end
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == LAST_IDX) ? B_WR : B_RD;
        end
        B_WR: begin
          if (slot_found_r) begin
            vld_r[slot_r] <= 1'b1;
          end else if (free_found_r) begin
            vld_r[free_r] <= 1'b1;
          end
          out_valid_r       <= 1'b1;
          out_status_r      <= (slot_found_r || free_found_r) ? STAT_UPDATED : STAT_FULL;
          out_hop_id_r      <= '0;
          out_link_stable_r <= stable_r;
          out_link_time_r   <= lt_r;
          out_removed_r     <= '0;
          state_r           <= S_IDLE;
        end
        X_RD: state_r <= X_CHK;
        X_CHK: begin
          if (vld_r[cnt_r] && age > cfg_timeout_r) begin
            vld_r[cnt_r] <= 1'b0;
            if (removed_r != REMOVED_MAX) begin
              removed_r <= removed_r + 6'd1;
            end
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= STAT_EXPIRED;
            out_hop_id_r      <= '0;
            out_link_stable_r <= 1'b0;
            out_link_time_r   <= '0;
            out_removed_r     <= (vld_r[cnt_r] && age > cfg_timeout_r &&
                                  removed_r != REMOVED_MAX) ? removed_r + 6'd1 : removed_r;
            state_r           <= S_IDLE;
          end else begin
            state_r <= X_RD;
          end
        end
        S_ARR: begin
          if (lat_id_r == cfg_own_id_r || own2 < 50'(ar2_r)) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= STAT_ARRIVED;
            out_hop_id_r      <= '0;
            out_link_stable_r <= 1'b0;
            out_link_time_r   <= '0;
            out_removed_r     <= '0;
            state_r           <= S_IDLE;
          end else if (!(lat_mode_r inside {MODE_GREEDY, MODE_LET, MODE_STABLE})) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= STAT_NO_HOP;
            out_hop_id_r      <= '0;
            out_link_stable_r <= 1'b0;
            out_link_time_r   <= '0;
            out_removed_r     <= '0;
            state_r           <= S_IDLE;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD:  state_r <= S_DAT;
        S_DAT: state_r <= S_SQE;
        S_SQE: state_r <= S_CMP;
        S_CMP: begin
          if (g_better) begin
            g_found_r <= 1'b1;
          end
          if (st_better) begin
            st_found_r <= 1'b1;
          end
          if (l_better) begin
            l_found_r <= 1'b1;
          end
          cnt_r   <= cnt_r + 1'b1;
          state_r <= (cnt_r == LAST_IDX) ? S_FIN : S_RD;
        end
        S_FIN: begin
          out_valid_r       <= 1'b1;
          out_hop_id_r      <= '0;
          out_link_stable_r <= 1'b0;
          out_link_time_r   <= '0;
          out_removed_r     <= '0;
          out_status_r      <= STAT_NO_HOP;
          case (lat_mode_r)
            MODE_LET: begin
              if (l_found_r) begin
                out_status_r <= STAT_FORWARD;
                out_hop_id_r <= l_id_r;
              end
            end
            MODE_STABLE: begin
              if (st_found_r) begin
                out_status_r <= STAT_FORWARD;
                out_hop_id_r <= st_id_r;
              end else if (g_found_r) begin
                out_status_r <= STAT_FORWARD;
                out_hop_id_r <= g_id_r;
              end
            end
            default: begin
              if (g_found_r) begin
                out_status_r <= STAT_FORWARD;
                out_hop_id_r <= g_id_r;
              end
            end
          endcase
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_hop_id        = out_hop_id_r;
  assign out_link_stable   = out_link_stable_r;
  assign out_link_time     = out_link_time_r;
  assign out_removed_count = out_removed_r;

  `NTS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `NTS_ASSERT_IMPLY(a_result_after_work, clk, rst_n, out_valid, $past(busy))
  `NTS_ASSERT_IMPLY(a_removed_only_expire, clk, rst_n,
                    out_valid && out_status != STAT_EXPIRED, out_removed_count == 6'd0)

endmodule

/* sv/nts_mem.sv */
module nts_mem #(
  parameter int ENTRIES = 32,
  parameter int ADDR_W  = 5
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  nts_pkg::nts_entry_t   wr_data,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output nts_pkg::nts_entry_t   rd_data
);
  import nts_pkg::*;

  nts_entry_t mem_r [ENTRIES];
  nts_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/nts_sqrt.sv */
module nts_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nts_pkg::nts_sqrt_req_t req,
  output logic                   done,
  output logic [31:0]            root
);
  import nts_pkg::*;

  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [63:0] b_r;
  logic        run_r;
  logic        done_r;
  logic [63:0] trial;

  assign trial = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && b_r == 64'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= req.radicand;
      r_r <= '0;
      b_r <= 64'd1 << 62;
    end else if (run_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r <= b_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

/* sv/nts_div.sv */
module nts_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nts_pkg::nts_div_req_t req,
  output logic                  done,
  output logic [63:0]           quotient
);
  import nts_pkg::*;

  logic [63:0] q_r;
  logic [33:0] rem_r;
  logic [33:0] dsr_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [34:0] trial;
  logic        fit;

  assign trial = {rem_r, q_r[63]};
  assign fit   = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 6'd63) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
      cnt_r <= '0;
    end else if (run_r) begin
      rem_r <= fit ? 34'(trial - {1'b0, dsr_r}) : trial[33:0];
      q_r   <= {q_r[62:0], fit};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
